FILE: hw/rtl/rhw_pkg.sv
// Shared types and codes for the recent hash window.
`timescale 1ns / 1ps

package rhw_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HASH_W = 4 * WORD_W;

	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [1:0]        action_t;
	typedef logic [6:0]        count_t;

	localparam action_t ACT_PUSH   = 2'd0;
	localparam action_t ACT_LOOKUP = 2'd1;
	localparam action_t ACT_READ   = 2'd2;

	localparam count_t WINDOW_RESET = 7'd64;

endpackage

FILE: hw/rtl/rhw_store.sv
// Hash storage: one write port, one registered read port.
`timescale 1ns / 1ps

module rhw_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  rhw_pkg::hash_t wr_data,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output rhw_pkg::hash_t rd_data
);
	import rhw_pkg::*;

	hash_t mem_q [DEPTH];
	hash_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/rhw_slot.sv
// Logical-to-physical slot mapping: (base + offset) mod cap, both below cap.
`timescale 1ns / 1ps

module rhw_slot (
	input  rhw_pkg::count_t base,
	input  rhw_pkg::count_t offset,
	input  rhw_pkg::count_t cap,
	output rhw_pkg::count_t slot
);
	import rhw_pkg::*;

	logic [7:0] sum;
	logic [7:0] wrapped;

	assign sum     = {1'b0, base} + {1'b0, offset};
	assign wrapped = sum - {1'b0, cap};
	assign slot    = (sum >= {1'b0, cap}) ? wrapped[6:0] : sum[6:0];

endmodule

FILE: hw/rtl/recent_hash_window.sv
// Recent hash window: ring of 256-bit hashes with push, lookup and read.
//
// Usage: drive action, hash_word_0..3 and position with start high; the item
// is taken at an edge where start is high and busy is low. Exactly one
// result follows per item, shown for one cycle with done high; the receiver
// cannot hold it off. window_size is written through cfg_valid/cfg_ready
// (ready only while idle) and empties the window.
// Steps from the accepting edge to the done cycle:
//   push or unused action : the scan state (a push writes), then done
//   read, position held   : one store read, registered, then done
//   read, position not held: no store read, then done
//   lookup                : one store read per held entry, ending early on a hit.
// The lookup time is set by the single store read port and the one 256-bit
// comparator, stepping through held entries one per cycle from the oldest.
// A new item may be started in the done cycle.
// Reset empties the window and sets window_size to 64; store contents are
// not cleared and are read only after they are written.
`timescale 1ns / 1ps

module recent_hash_window #(
	parameter int unsigned MAX_ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  rhw_pkg::count_t      window_size,
	input  logic                 start,
	output logic                 busy,
	input  rhw_pkg::action_t     action,
	input  logic [63:0]          hash_word_0,
	input  logic [63:0]          hash_word_1,
	input  logic [63:0]          hash_word_2,
	input  logic [63:0]          hash_word_3,
	input  logic [5:0]           position,
	output logic                 done,
	output logic                 found,
	output logic                 position_valid,
	output logic [63:0]          entry_word_0,
	output logic [63:0]          entry_word_1,
	output logic [63:0]          entry_word_2,
	output logic [63:0]          entry_word_3,
	output rhw_pkg::count_t      entry_count
);
	import rhw_pkg::*;

	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam count_t CAP_LIMIT = 7'((MAX_ENTRIES > 127) ? 127 : MAX_ENTRIES);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic    state_q;
	count_t  win_size_q;
	count_t  oldest_q;
	count_t  held_q;
	action_t act_q;
	hash_t   hash_q;
	count_t  idx_q;
	count_t  end_q;
	logic    pend_q;

	logic    done_q;
	logic    found_q;
	logic    pos_valid_q;
	hash_t   entry_q;
	count_t  count_q;

	count_t  cap;
	logic    full;
	logic    accept;
	logic    is_push;
	logic    hit;
	logic    finish;
	logic    issue;
	logic    wr_en;
	count_t  logical_sel;
	count_t  slot;
	count_t  oldest_inc;
	count_t  held_next;
	hash_t   rd_data;

	assign cap = (32'(win_size_q) > 32'(MAX_ENTRIES)) ? CAP_LIMIT : win_size_q;
	assign full = held_q >= cap;
	assign accept = start && (state_q == ST_IDLE);
	assign is_push = act_q == ACT_PUSH;

	assign hit    = pend_q && (act_q == ACT_LOOKUP) && (rd_data == hash_q);
	assign finish = (state_q == ST_SCAN) && (hit || ((idx_q == end_q) && !pend_q));
	assign issue  = (state_q == ST_SCAN) && !is_push && (idx_q != end_q);
	assign wr_en  = (state_q == ST_SCAN) && is_push && (cap != 7'd0);

	// push writes after the newest entry, or over the oldest once full
	assign logical_sel = is_push ? (full ? 7'd0 : held_q) : idx_q;
	assign oldest_inc  = (oldest_q + 7'd1 == cap) ? 7'd0 : oldest_q + 7'd1;
	assign held_next   = (wr_en && !full) ? held_q + 7'd1 : held_q;

	rhw_slot u_slot (
		.base   (oldest_q),
		.offset (logical_sel),
		.cap    (cap),
		.slot   (slot)
	);

	rhw_store #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(slot)),
		.wr_data (hash_q),
		.rd_en   (issue),
		.rd_addr (AW'(slot)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_size_q  <= WINDOW_RESET;
			oldest_q    <= 7'd0;
			held_q      <= 7'd0;
			pend_q      <= 1'b0;
			done_q      <= 1'b0;
			idx_q       <= 7'd0;
			end_q       <= 7'd0;
			act_q       <= ACT_PUSH;
			found_q     <= 1'b0;
			pos_valid_q <= 1'b0;
			count_q     <= 7'd0;
		end else begin
			done_q <= finish;
			if (cfg_valid && cfg_ready) begin
				win_size_q <= window_size;
				oldest_q   <= 7'd0;
				held_q     <= 7'd0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q     <= ST_SCAN;
						act_q       <= action;
						pend_q      <= 1'b0;
						found_q     <= 1'b0;
						pos_valid_q <= 1'b0;
						case (action)
							ACT_LOOKUP: begin
								idx_q <= 7'd0;
								end_q <= held_q;
							end
							ACT_READ: begin
								idx_q <= {1'b0, position};
								end_q <= ({1'b0, position} < held_q) ?
									{1'b0, position} + 7'd1 : {1'b0, position};
							end
							default: begin
								idx_q <= 7'd0;
								end_q <= 7'd0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_q + 7'd1;
					end
					if (pend_q && (act_q == ACT_READ)) begin
						pos_valid_q <= 1'b1;
					end
					if (wr_en) begin
						held_q <= held_next;
						if (full) begin
							oldest_q <= oldest_inc;
						end
					end
					if (finish) begin
						state_q <= ST_IDLE;
						found_q <= hit;
						count_q <= held_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// entry payload: cleared per item, loaded from the store on a read
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q <= '0;
			hash_q  <= {hash_word_3, hash_word_2, hash_word_1, hash_word_0};
		end else if ((state_q == ST_SCAN) && pend_q && (act_q == ACT_READ)) begin
			entry_q <= rd_data;
		end
	end

	assign cfg_ready      = state_q == ST_IDLE;
	assign busy           = state_q != ST_IDLE;
	assign done           = done_q;
	assign found          = found_q;
	assign position_valid = pos_valid_q;
	assign entry_word_0   = entry_q[0*WORD_W +: WORD_W];
	assign entry_word_1   = entry_q[1*WORD_W +: WORD_W];
	assign entry_word_2   = entry_q[2*WORD_W +: WORD_W];
	assign entry_word_3   = entry_q[3*WORD_W +: WORD_W];
	assign entry_count    = count_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_held_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= cap)
		else $error("held count exceeds window capacity");

	a_oldest_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cap == 7'd0) ? (oldest_q == 7'd0) : (oldest_q < cap))
		else $error("oldest slot outside window");

	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(found_q && pos_valid_q))
		else $error("lookup hit and read valid in one result");

	a_write_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en || issue) |-> (state_q == ST_SCAN) && !(wr_en && issue))
		else $error("store access outside scan or write and read together");

endmodule
